>>> sv/pfl_pkg.sv
// shared types and constants for the page replacement unit
package pfl_pkg;

    localparam int DEF_NUM_FRAMES = 4;
    localparam int DEF_NUM_PAGES  = 8;
    localparam int DEF_STAMP_BITS = 32;
    localparam int COUNT_W        = 32;

    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_UPDATE
    } t_state;

    // sequencer commands to the scan unit
    typedef struct packed {
        logic clear;
        logic cmp_en;
    } t_scan_ctl;

    // scan unit findings
    typedef struct packed {
        logic hit;
        logic free_found;
    } t_scan_flags;

endpackage

>>> sv/page_replacement_fifo_lru.sv
// page replacement unit top level: sequencer, counters and output register
//
// usage:
//   input channel (i_in_valid / o_in_ready) carries one page number per
//   transaction; a page at or above NUM_PAGES wraps modulo NUM_PAGES.
//   output channel (o_out_valid / i_out_ready) returns one result per access:
//   hit flag, frame used, eviction flag and page, running hit and fault totals.
//   i_cfg_wr_en / i_cfg_wr_data set the victim policy (0 fifo, 1 lru); write
//   it only while no access is in flight.
// timing:
//   from acceptance until the input is ready again an access passes the idle
//   state that accepts it, the scan state that reads the frame store one entry
//   per frame, the drain state for the last compare and the update state, which
//   waits while a held result is not taken. The shared compare unit visits each frame once.
//   the result appears on the output the cycle after the update.
// reset (synchronous, active low) empties all frames and clears the tick,
// the totals and the policy. the output register holds one result; while the
// receiver stalls a new access may be accepted and scanned, but its update
// waits until the held result is taken.
module page_replacement_fifo_lru #(
    parameter int NUM_FRAMES = pfl_pkg::DEF_NUM_FRAMES,
    parameter int NUM_PAGES  = pfl_pkg::DEF_NUM_PAGES,
    parameter int STAMP_BITS = pfl_pkg::DEF_STAMP_BITS,
    localparam int FRAME_W   = $clog2(NUM_FRAMES),
    localparam int PAGE_W    = $clog2(NUM_PAGES)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [PAGE_W-1:0]           i_page_number,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_hit,
    output logic [FRAME_W-1:0]          o_frame_used,
    output logic                        o_evicted,
    output logic [PAGE_W-1:0]           o_evicted_page,
    output logic [pfl_pkg::COUNT_W-1:0] o_hit_total,
    output logic [pfl_pkg::COUNT_W-1:0] o_fault_total
);

    localparam int CW = pfl_pkg::COUNT_W;

    pfl_pkg::t_state r_state, n_state;

    logic                  r_mode;
    logic [PAGE_W-1:0]     r_page;
    logic [STAMP_BITS-1:0] r_tick;
    logic [FRAME_W-1:0]    r_idx;
    logic                  r_cmp_vld;
    logic [FRAME_W-1:0]    r_cmp_idx;
    logic [CW-1:0]         r_hit_count;
    logic [CW-1:0]         r_fault_count;

    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [FRAME_W-1:0]    r_out_frame;
    logic                  r_out_evicted;
    logic [PAGE_W-1:0]     r_out_ev_page;

    logic                  in_fire;
    logic                  commit;
    logic [PAGE_W:0]       page_ext;
    logic [PAGE_W-1:0]     page_mod;
    logic [STAMP_BITS-1:0] n_tick;

    pfl_pkg::t_scan_ctl    scan_ctl;
    pfl_pkg::t_scan_flags  scan_flags;
    logic [FRAME_W-1:0]    hit_idx;
    logic [STAMP_BITS-1:0] hit_load;
    logic [FRAME_W-1:0]    free_idx;
    logic [FRAME_W-1:0]    best_idx;
    logic [PAGE_W-1:0]     best_page;

    logic                  rd_valid;
    logic [PAGE_W-1:0]     rd_page;
    logic [STAMP_BITS-1:0] rd_load;
    logic [STAMP_BITS-1:0] rd_use;

    logic                  wr_en;
    logic [FRAME_W-1:0]    wr_addr;
    logic [STAMP_BITS-1:0] wr_load;

    logic                  upd_evicted;
    logic [PAGE_W-1:0]     upd_ev_page;

    // input wrap and saturating tick
    always_comb begin
        page_ext = {1'b0, i_page_number};
        if (page_ext >= (PAGE_W+1)'(NUM_PAGES)) begin
            page_mod = PAGE_W'(page_ext - (PAGE_W+1)'(NUM_PAGES));
        end else begin
            page_mod = i_page_number;
        end
        n_tick = (&r_tick) ? r_tick : r_tick + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        scan_ctl     = '0;
        commit       = 1'b0;
        in_fire      = 1'b0;
        case (r_state)
            pfl_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                in_fire        = i_in_valid;
                scan_ctl.clear = i_in_valid;
                if (i_in_valid) begin
                    n_state = pfl_pkg::S_SCAN;
                end
            end
            pfl_pkg::S_SCAN: begin
                scan_ctl.cmp_en = r_cmp_vld;
                if (r_idx == FRAME_W'(NUM_FRAMES - 1)) begin
                    n_state = pfl_pkg::S_DRAIN;
                end
            end
            pfl_pkg::S_DRAIN: begin
                scan_ctl.cmp_en = r_cmp_vld;
                n_state         = pfl_pkg::S_UPDATE;
            end
            pfl_pkg::S_UPDATE: begin
                // wait until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    commit  = 1'b1;
                    n_state = pfl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfl_pkg::S_IDLE;
            end
        endcase
    end

    // update decision from the scan findings
    always_comb begin
        upd_evicted = !scan_flags.hit && !scan_flags.free_found;
        upd_ev_page = upd_evicted ? best_page : '0;
        if (scan_flags.hit) begin
            wr_addr = hit_idx;
            wr_load = hit_load;
        end else begin
            wr_addr = scan_flags.free_found ? free_idx : best_idx;
            wr_load = r_tick;
        end
        wr_en = commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= pfl_pkg::MODE_FIFO;
            r_tick        <= '0;
            r_hit_count   <= '0;
            r_fault_count <= '0;
            r_cmp_vld     <= 1'b0;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (in_fire) begin
                r_tick <= n_tick;
                r_idx  <= '0;
            end else if (r_state == pfl_pkg::S_SCAN) begin
                r_idx <= r_idx + 1'b1;
            end
            r_cmp_vld <= (r_state == pfl_pkg::S_SCAN);
            if (commit) begin
                if (scan_flags.hit) begin
                    r_hit_count <= (&r_hit_count) ? r_hit_count : r_hit_count + 1'b1;
                end else begin
                    r_fault_count <= (&r_fault_count) ? r_fault_count
                                                      : r_fault_count + 1'b1;
                end
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_page <= page_mod;
        end
        r_cmp_idx <= r_idx;
        if (commit) begin
            r_out_hit     <= scan_flags.hit;
            r_out_frame   <= wr_addr;
            r_out_evicted <= upd_evicted;
            r_out_ev_page <= upd_ev_page;
        end
    end

    pfl_frame_mem #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_W     (PAGE_W),
        .STAMP_BITS (STAMP_BITS)
    ) u_frame_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (r_idx),
        .o_rd_valid (rd_valid),
        .o_rd_page  (rd_page),
        .o_rd_load  (rd_load),
        .o_rd_use   (rd_use),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_page  (r_page),
        .i_wr_load  (wr_load),
        .i_wr_use   (r_tick)
    );

    pfl_scan_unit #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_W     (PAGE_W),
        .STAMP_BITS (STAMP_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_mode      (r_mode),
        .i_target    (r_page),
        .i_idx       (r_cmp_idx),
        .i_valid     (rd_valid),
        .i_page      (rd_page),
        .i_load      (rd_load),
        .i_use       (rd_use),
        .o_flags     (scan_flags),
        .o_hit_idx   (hit_idx),
        .o_hit_load  (hit_load),
        .o_free_idx  (free_idx),
        .o_best_idx  (best_idx),
        .o_best_page (best_page)
    );

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_frame_used   = r_out_frame;
    assign o_evicted      = r_out_evicted;
    assign o_evicted_page = r_out_ev_page;
    assign o_hit_total    = r_hit_count;
    assign o_fault_total  = r_fault_count;

    // a new transaction always starts the scan at frame zero
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == pfl_pkg::S_SCAN) && (r_idx == '0))
        else $error("scan did not start at frame zero");

    // a hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (!o_evicted && (o_evicted_page == '0)))
        else $error("eviction reported on a hit");

    // an update never overwrites a result still waiting at the output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_out_valid) |-> i_out_ready)
        else $error("held result overwritten");

    a_tick_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_tick >= $past(r_tick)))
        else $error("tick went backwards");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_hit_count >= $past(r_hit_count))
                  && (r_fault_count >= $past(r_fault_count))))
        else $error("hit or fault total went backwards");

endmodule

>>> sv/pfl_frame_mem.sv
// frame store: page and stamp memory with per-frame valid bits
module pfl_frame_mem #(
    parameter int NUM_FRAMES = pfl_pkg::DEF_NUM_FRAMES,
    parameter int PAGE_W     = $clog2(pfl_pkg::DEF_NUM_PAGES),
    parameter int STAMP_BITS = pfl_pkg::DEF_STAMP_BITS,
    localparam int FRAME_W   = $clog2(NUM_FRAMES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [FRAME_W-1:0]    i_rd_addr,
    output logic                  o_rd_valid,
    output logic [PAGE_W-1:0]     o_rd_page,
    output logic [STAMP_BITS-1:0] o_rd_load,
    output logic [STAMP_BITS-1:0] o_rd_use,
    input  logic                  i_wr_en,
    input  logic [FRAME_W-1:0]    i_wr_addr,
    input  logic [PAGE_W-1:0]     i_wr_page,
    input  logic [STAMP_BITS-1:0] i_wr_load,
    input  logic [STAMP_BITS-1:0] i_wr_use
);

    logic [PAGE_W-1:0]     r_mem_page [NUM_FRAMES];
    logic [STAMP_BITS-1:0] r_mem_load [NUM_FRAMES];
    logic [STAMP_BITS-1:0] r_mem_use  [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] r_valid;

    logic                  r_rd_valid;
    logic [PAGE_W-1:0]     r_rd_page;
    logic [STAMP_BITS-1:0] r_rd_load;
    logic [STAMP_BITS-1:0] r_rd_use;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_page[i_wr_addr] <= i_wr_page;
            r_mem_load[i_wr_addr] <= i_wr_load;
            r_mem_use[i_wr_addr]  <= i_wr_use;
        end
        r_rd_page <= r_mem_page[i_rd_addr];
        r_rd_load <= r_mem_load[i_rd_addr];
        r_rd_use  <= r_mem_use[i_rd_addr];
    end

    // valid bits are flops so reset empties every frame at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_page  = r_rd_page;
    assign o_rd_load  = r_rd_load;
    assign o_rd_use   = r_rd_use;

endmodule

>>> sv/pfl_scan_unit.sv
// shared compare unit: page match, free frame and oldest stamp, one frame a cycle
module pfl_scan_unit #(
    parameter int NUM_FRAMES = pfl_pkg::DEF_NUM_FRAMES,
    parameter int PAGE_W     = $clog2(pfl_pkg::DEF_NUM_PAGES),
    parameter int STAMP_BITS = pfl_pkg::DEF_STAMP_BITS,
    localparam int FRAME_W   = $clog2(NUM_FRAMES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pfl_pkg::t_scan_ctl    i_ctl,
    input  logic                  i_mode,
    input  logic [PAGE_W-1:0]     i_target,
    input  logic [FRAME_W-1:0]    i_idx,
    input  logic                  i_valid,
    input  logic [PAGE_W-1:0]     i_page,
    input  logic [STAMP_BITS-1:0] i_load,
    input  logic [STAMP_BITS-1:0] i_use,
    output pfl_pkg::t_scan_flags  o_flags,
    output logic [FRAME_W-1:0]    o_hit_idx,
    output logic [STAMP_BITS-1:0] o_hit_load,
    output logic [FRAME_W-1:0]    o_free_idx,
    output logic [FRAME_W-1:0]    o_best_idx,
    output logic [PAGE_W-1:0]     o_best_page
);

    pfl_pkg::t_scan_flags  r_flags;
    logic [FRAME_W-1:0]    r_hit_idx;
    logic [STAMP_BITS-1:0] r_hit_load;
    logic [FRAME_W-1:0]    r_free_idx;
    logic [FRAME_W-1:0]    r_best_idx;
    logic [PAGE_W-1:0]     r_best_page;
    logic [STAMP_BITS-1:0] r_best;

    logic [STAMP_BITS-1:0] sel_stamp;
    logic                  is_hit;
    logic                  is_free;
    logic                  take_best;

    always_comb begin
        sel_stamp = (i_mode == pfl_pkg::MODE_LRU) ? i_use : i_load;
        is_hit    = i_valid && (i_page == i_target);
        is_free   = !i_valid && !r_flags.free_found;
        // strict less keeps ties on the lowest frame
        take_best = (i_idx == '0) || (sel_stamp < r_best);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_ctl.clear) begin
            r_flags <= '0;
        end else if (i_ctl.cmp_en) begin
            if (is_hit) begin
                r_flags.hit <= 1'b1;
            end
            if (is_free) begin
                r_flags.free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            if (is_hit) begin
                r_hit_idx  <= i_idx;
                r_hit_load <= i_load;
            end
            if (is_free) begin
                r_free_idx <= i_idx;
            end
            if (take_best) begin
                r_best      <= sel_stamp;
                r_best_idx  <= i_idx;
                r_best_page <= i_page;
            end
        end
    end

    assign o_flags     = r_flags;
    assign o_hit_idx   = r_hit_idx;
    assign o_hit_load  = r_hit_load;
    assign o_free_idx  = r_free_idx;
    assign o_best_idx  = r_best_idx;
    assign o_best_page = r_best_page;

endmodule

>>> verif/page_replacement_fifo_lru_tb.sv
// testbench for the fifo / lru page replacement unit
`timescale 1ns / 1ps

module page_replacement_fifo_lru_tb;

    localparam int  NUM_FRAMES   = pfl_pkg::DEF_NUM_FRAMES;
    localparam int  NUM_PAGES    = pfl_pkg::DEF_NUM_PAGES;
    localparam int  COUNT_W      = pfl_pkg::COUNT_W;
    localparam int  FRAME_W      = $clog2(NUM_FRAMES);
    localparam int  PAGE_W       = $clog2(NUM_PAGES);
    localparam int  STAMP_W      = pfl_pkg::DEF_STAMP_BITS;
    localparam int  SETTLE_CYCLES = 2 * NUM_FRAMES + 8;
    localparam int  QUIET_LIMIT  = 2000;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  IDLE_PCT     = 14;
    localparam int  MAX_REPORTS  = 10;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_used;
        logic               evicted;
        logic [PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] fault_total;
    } t_access_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic               i_cfg_wr_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [PAGE_W-1:0]  i_page_number;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_hit;
    logic [FRAME_W-1:0] o_frame_used;
    logic               o_evicted;
    logic [PAGE_W-1:0]  o_evicted_page;
    logic [COUNT_W-1:0] o_hit_total;
    logic [COUNT_W-1:0] o_fault_total;

    page_replacement_fifo_lru u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_page_number  (i_page_number),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hit          (o_hit),
        .o_frame_used   (o_frame_used),
        .o_evicted      (o_evicted),
        .o_evicted_page (o_evicted_page),
        .o_hit_total    (o_hit_total),
        .o_fault_total  (o_fault_total)
    );

    // predictor state
    logic                 victim_policy;
    logic                 page_resident [NUM_PAGES];
    logic [FRAME_W-1:0]   page_frame    [NUM_PAGES];
    logic [PAGE_W-1:0]    frame_owner   [NUM_FRAMES];
    logic                 frame_busy    [NUM_FRAMES];
    logic [STAMP_W-1:0]   loaded_at     [NUM_FRAMES];
    logic [STAMP_W-1:0]   touched_at    [NUM_FRAMES];
    logic [STAMP_W-1:0]   access_tick;
    logic [COUNT_W-1:0]   hits_seen;
    logic [COUNT_W-1:0]   faults_seen;

    t_access_result pending_results[$];

    bit          tx_idle_en;
    bit          rx_idle_en;
    int unsigned rx_hold_left;
    int unsigned mismatch_count;
    int unsigned error_count;
    int unsigned quiet_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic clear_predictor();
        victim_policy = pfl_pkg::MODE_FIFO;
        for (int p = 0; p < NUM_PAGES; p++) begin
            page_resident[p] = 1'b0;
            page_frame[p]    = '0;
        end
        for (int f = 0; f < NUM_FRAMES; f++) begin
            frame_owner[f] = '0;
            frame_busy[f]  = 1'b0;
            loaded_at[f]   = '0;
            touched_at[f]  = '0;
        end
        access_tick = '0;
        hits_seen   = '0;
        faults_seen = '0;
    endtask

    function automatic t_access_result predict_access(input logic [PAGE_W-1:0] page);
        t_access_result     r;
        logic [FRAME_W-1:0] slot;
        logic [STAMP_W-1:0] oldest;
        logic [STAMP_W-1:0] cand;
        bit                 free_found;

        r = '0;
        slot = '0;
        free_found = 1'b0;
        if (access_tick != '1)
            access_tick = access_tick + 1'b1;

        if (page_resident[page]) begin
            slot = page_frame[page];
            r.hit = 1'b1;
            hits_seen = sat_inc(hits_seen);
            touched_at[slot] = access_tick;
        end else begin
            faults_seen = sat_inc(faults_seen);
            for (int f = 0; f < NUM_FRAMES; f++) begin
                if (!free_found && !frame_busy[f]) begin
                    slot = FRAME_W'(f);
                    free_found = 1'b1;
                end
            end
            if (!free_found) begin
                // strict compare keeps ties on the lowest frame
                oldest = (victim_policy == pfl_pkg::MODE_LRU) ? touched_at[0]
                                                              : loaded_at[0];
                for (int f = 1; f < NUM_FRAMES; f++) begin
                    cand = (victim_policy == pfl_pkg::MODE_LRU) ? touched_at[f]
                                                                : loaded_at[f];
                    if (cand < oldest) begin
                        oldest = cand;
                        slot = FRAME_W'(f);
                    end
                end
                r.evicted = 1'b1;
                r.evicted_page = frame_owner[slot];
                page_resident[frame_owner[slot]] = 1'b0;
                page_frame[frame_owner[slot]] = '0;
            end
            frame_owner[slot] = page;
            frame_busy[slot]  = 1'b1;
            loaded_at[slot]   = access_tick;
            touched_at[slot]  = access_tick;
            page_resident[page] = 1'b1;
            page_frame[page]    = slot;
        end
        r.frame_used  = slot;
        r.hit_total   = hits_seen;
        r.fault_total = faults_seen;
        return r;
    endfunction

    // offer one page; returns at the rising edge that accepts it, valid left high
    task automatic send_page(input logic [PAGE_W-1:0] page);
        @(negedge i_clk);
        while (tx_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_page_number <= page;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pending_results.push_back(predict_access(page));
    endtask

    task automatic drain_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_policy(input logic mode);
        drain_block();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        victim_policy = mode;
    endtask

    function automatic logic [PAGE_W-1:0] pick_page(input logic [PAGE_W-1:0] hot_base);
        // mostly a small working set so hits and evictions both happen
        if ($urandom_range(0, 99) < 70)
            return hot_base + PAGE_W'($urandom_range(0, NUM_FRAMES));
        return PAGE_W'($urandom_range(0, NUM_PAGES - 1));
    endfunction

    task automatic test_fill_and_hit();
        logic [PAGE_W-1:0] seq [6] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd1, 3'd3};
        set_policy(pfl_pkg::MODE_FIFO);
        foreach (seq[k]) send_page(seq[k]);
    endtask

    task automatic test_fifo_victim();
        logic [PAGE_W-1:0] seq [6] = '{3'd4, 3'd5, 3'd4, 3'd0, 3'd6, 3'd7};
        foreach (seq[k]) send_page(seq[k]);
    endtask

    task automatic test_lru_victim();
        logic [PAGE_W-1:0] seq [8] = '{3'd7, 3'd2, 3'd6, 3'd7, 3'd1, 3'd3, 3'd2, 3'd0};
        set_policy(pfl_pkg::MODE_LRU);
        foreach (seq[k]) send_page(seq[k]);
    endtask

    task automatic test_output_stall();
        logic [PAGE_W-1:0] hot;
        drain_block();
        hot = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
        rx_hold_left = HOLD_CYCLES;
        repeat (25) send_page(pick_page(hot));
    endtask

    task automatic test_random_access();
        logic [PAGE_W-1:0] hot;
        for (int phase = 0; phase < 5; phase++) begin
            set_policy((phase % 2 == 0) ? pfl_pkg::MODE_FIFO : pfl_pkg::MODE_LRU);
            // one phase runs flat out on both sides
            tx_idle_en = (phase != 2);
            rx_idle_en = (phase != 2);
            hot = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(0, 29) == 0)
                    hot = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
                send_page(pick_page(hot));
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // receiver: random stalls, or a long counted hold-off when asked
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left != 0) begin
                i_out_ready <= 1'b0;
                rx_hold_left = rx_hold_left - 1;
            end else begin
                i_out_ready <= !(rx_idle_en && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            error_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch %s: expected %0d got %0d at %0t",
                         name, want, got, $realtime);
        end
    endtask

    always @(posedge i_clk) begin
        t_access_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("result transaction with nothing expected at %0t", $realtime);
            end else begin
                want = pending_results.pop_front();
                check_field("hit", COUNT_W'(want.hit), COUNT_W'(o_hit));
                check_field("frame_used", COUNT_W'(want.frame_used),
                            COUNT_W'(o_frame_used));
                check_field("evicted", COUNT_W'(want.evicted), COUNT_W'(o_evicted));
                check_field("evicted_page", COUNT_W'(want.evicted_page),
                            COUNT_W'(o_evicted_page));
                check_field("hit_total", want.hit_total, o_hit_total);
                check_field("fault_total", want.fault_total, o_fault_total);
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = 1'b0;
        i_in_valid     = 1'b0;
        i_page_number  = '0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        rx_hold_left   = 0;
        mismatch_count = 0;
        error_count    = 0;
        clear_predictor();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_fill_and_hit();
        test_fifo_victim();
        test_lru_victim();
        test_output_stall();
        test_random_access();
        drain_block();

        if (pending_results.size() != 0)
            error_count++;
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
